/* sv/zae_pkg.sv */
package zae_pkg;

  // field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned MonoW   = 32;
  localparam int unsigned TermW   = 38;
  localparam int unsigned ProdW   = TermW + WeightW;
  localparam int unsigned AccW    = 64;
  localparam int unsigned ResW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned Word3W  = 48;

  localparam int unsigned NumTerms  = 15;
  localparam int unsigned NumWords  = 4;
  localparam int unsigned NumGroups = 4;
  localparam int unsigned GroupSize = 4;

  // rounding and fraction shifts
  localparam int unsigned Deg3Shift = 15;
  localparam int unsigned Deg4Shift = 30;
  localparam int unsigned OutShift  = 26;

  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic signed [WeightW-1:0] weight_t;
  typedef logic signed [MonoW-1:0]   mono_t;
  typedef logic signed [TermW-1:0]   term_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [AccW-1:0]    acc_t;
  typedef logic signed [ResW-1:0]    res_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgWord0 = 3'd0,
    CfgWord1 = 3'd1,
    CfgWord2 = 3'd2,
    CfgWord3 = 3'd3
  } cfg_idx_e;

  localparam term_t OneQ30 = term_t'(64'sd1 <<< 30);
  localparam acc_t  RoundHalf = acc_t'(64'sd1 <<< (OutShift - 1));
  localparam acc_t  ResMax = acc_t'(64'sd2147483647);
  localparam acc_t  ResMin = acc_t'(-64'sd2147483648);

endpackage

/* sv/zernike_aberration_eval.sv */
// channel   direction  handshake                       payload
// request   in         start & !busy                   pupil_x_i, pupil_y_i
// result    out        result_valid_o (one cycle)      aberration_o, saturated_o
// config    in         cfg_valid_i & cfg_ready_o       cfg_index_i, cfg_data_i
//
// seven register stages: input, squares, degree 3 and 4 monomials, zernike
// terms, weighted products, partial sums, rounded and clipped output
// one request is taken every cycle; each result passes through every stage above
// in order and is registered at the output stage before it reaches the ports
// busy stays low: the receiver cannot stall, so the pipeline never holds
// reset clears the stage valid bits and all weights to zero
module zernike_aberration_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  zae_pkg::coord_t               pupil_x_i,
  input  zae_pkg::coord_t               pupil_y_i,
  output logic                          result_valid_o,
  output zae_pkg::res_t                 aberration_o,
  output logic                          saturated_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [zae_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [zae_pkg::CfgDataW-1:0]  cfg_data_i
);
  import zae_pkg::*;

  logic [CfgDataW-1:0] coeff_q [NumWords];
  weight_t             weight  [NumTerms];

  logic [6:0] vld_q;

  coord_t  s1_x_q, s1_y_q;
  coord_t  s2_x_q, s2_y_q;
  mono_t   s2_x2_q, s2_y2_q, s2_xy_q;
  mono_t   s3_x2_q, s3_y2_q, s3_xy_q;
  coord_t  s3_x_q, s3_y_q;
  mono_t   s3_x3_q, s3_y3_q, s3_x2y_q, s3_xy2_q;
  mono_t   s3_x4_q, s3_y4_q, s3_x2y2_q, s3_x3y_q, s3_xy3_q;
  term_t   z_d [NumTerms];
  term_t   z_q [NumTerms];
  prod_t   prod_q [NumTerms];
  acc_t    part_d [NumGroups];
  acc_t    part_q [NumGroups];
  acc_t    total;
  acc_t    rounded;
  res_t    res_d, res_q;
  logic    sat_d, sat_q;

  logic signed [47:0] p_x3, p_y3, p_x2y, p_xy2;
  logic signed [63:0] p_x4, p_y4, p_x2y2, p_x3y, p_xy3;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // weight i sits in word i/4, field i%4
  always_comb begin
    for (int i = 0; i < NumTerms; i++) begin
      weight[i] = weight_t'(coeff_q[i / GroupSize][(i % GroupSize) * WeightW +: WeightW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) coeff_q[i] <= '0;
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], start & ~busy};
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgWord0: coeff_q[0] <= cfg_data_i;
          CfgWord1: coeff_q[1] <= cfg_data_i;
          CfgWord2: coeff_q[2] <= cfg_data_i;
          CfgWord3: coeff_q[3] <= {{(CfgDataW - Word3W){1'b0}}, cfg_data_i[Word3W-1:0]};
          default: ;
        endcase
      end
    end
  end

  // degree 3 and 4 products; arithmetic shift gives the floor
  assign p_x3   = s2_x2_q * s2_x_q;
  assign p_y3   = s2_y2_q * s2_y_q;
  assign p_x2y  = s2_x2_q * s2_y_q;
  assign p_xy2  = s2_y2_q * s2_x_q;
  assign p_x4   = s2_x2_q * s2_x2_q;
  assign p_y4   = s2_y2_q * s2_y2_q;
  assign p_x2y2 = s2_x2_q * s2_y2_q;
  assign p_x3y  = s2_x2_q * s2_xy_q;
  assign p_xy3  = s2_xy_q * s2_y2_q;

  always_comb begin
    term_t x1, y1, x2, y2, xy, x3, y3, x2y, xy2, x4, y4, x2y2, x3y, xy3;
    x1   = term_t'(s3_x_q) <<< Deg3Shift;
    y1   = term_t'(s3_y_q) <<< Deg3Shift;
    x2   = term_t'(s3_x2_q);
    y2   = term_t'(s3_y2_q);
    xy   = term_t'(s3_xy_q);
    x3   = term_t'(s3_x3_q);
    y3   = term_t'(s3_y3_q);
    x2y  = term_t'(s3_x2y_q);
    xy2  = term_t'(s3_xy2_q);
    x4   = term_t'(s3_x4_q);
    y4   = term_t'(s3_y4_q);
    x2y2 = term_t'(s3_x2y2_q);
    x3y  = term_t'(s3_x3y_q);
    xy3  = term_t'(s3_xy3_q);
    z_d[0]  = OneQ30;
    z_d[1]  = y1;
    z_d[2]  = x1;
    z_d[3]  = 2 * (x2 + y2) - OneQ30;
    z_d[4]  = y2 - x2;
    z_d[5]  = 2 * xy;
    z_d[6]  = -2 * y1 + 3 * y3 + 3 * x2y;
    z_d[7]  = -2 * x1 + 3 * x3 + 3 * xy2;
    z_d[8]  = y3 - 3 * x2y;
    z_d[9]  = 3 * xy2 - x3;
    z_d[10] = OneQ30 - 6 * x2 - 6 * y2 + 6 * x4 + 12 * x2y2 + 6 * y4;
    z_d[11] = 3 * x2 - 3 * y2 - 4 * x4 + 4 * y4;
    z_d[12] = -6 * xy + 8 * x3y + 8 * xy3;
    z_d[13] = x4 - 6 * x2y2 + y4;
    z_d[14] = 4 * xy3 - 4 * x3y;
  end

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        if (g * GroupSize + k < NumTerms) begin
          part_d[g] = part_d[g] + acc_t'(prod_q[g * GroupSize + k]);
        end
      end
    end
  end

  // round half up to Q16.16, then clip
  always_comb begin
    total   = part_q[0] + part_q[1] + part_q[2] + part_q[3];
    rounded = (total + RoundHalf) >>> OutShift;
    sat_d   = 1'b0;
    res_d   = res_t'(rounded);
    if (rounded > ResMax) begin
      res_d = res_t'(ResMax);
      sat_d = 1'b1;
    end else if (rounded < ResMin) begin
      res_d = res_t'(ResMin);
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q <= pupil_x_i;
    s1_y_q <= pupil_y_i;

    s2_x_q  <= s1_x_q;
    s2_y_q  <= s1_y_q;
    s2_x2_q <= s1_x_q * s1_x_q;
    s2_y2_q <= s1_y_q * s1_y_q;
    s2_xy_q <= s1_x_q * s1_y_q;

    s3_x_q    <= s2_x_q;
    s3_y_q    <= s2_y_q;
    s3_x2_q   <= s2_x2_q;
    s3_y2_q   <= s2_y2_q;
    s3_xy_q   <= s2_xy_q;
    s3_x3_q   <= p_x3[Deg3Shift +: MonoW];
    s3_y3_q   <= p_y3[Deg3Shift +: MonoW];
    s3_x2y_q  <= p_x2y[Deg3Shift +: MonoW];
    s3_xy2_q  <= p_xy2[Deg3Shift +: MonoW];
    s3_x4_q   <= p_x4[Deg4Shift +: MonoW];
    s3_y4_q   <= p_y4[Deg4Shift +: MonoW];
    s3_x2y2_q <= p_x2y2[Deg4Shift +: MonoW];
    s3_x3y_q  <= p_x3y[Deg4Shift +: MonoW];
    s3_xy3_q  <= p_xy3[Deg4Shift +: MonoW];

    for (int i = 0; i < NumTerms; i++) begin
      z_q[i]    <= z_d[i];
      prod_q[i] <= z_q[i] * weight[i];
    end
    for (int g = 0; g < NumGroups; g++) part_q[g] <= part_d[g];

    res_q <= res_d;
    sat_q <= sat_d;
  end

  assign result_valid_o = vld_q[6];
  assign aberration_o   = res_q;
  assign saturated_o    = sat_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##7 result_valid_o)
    else $error("request did not produce a result after seven cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, 7))
    else $error("result without a matching request");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && saturated_o) |->
      (aberration_o == 32'sh7fffffff || aberration_o == 32'sh80000000))
    else $error("saturation flagged on an unclipped value");

endmodule

/* tb/zernike_aberration_eval_test.sv */
`timescale 1ns / 1ps

module zernike_aberration_eval_test;
  import zae_pkg::*;

  localparam int unsigned ClkPeriod      = 12;
  localparam int unsigned ResetCycles    = 10;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned DrainCycles    = 16;
  localparam int unsigned NumPhases      = 6;
  localparam int unsigned PointsPerPhase = 200;
  localparam int unsigned MaxPrinted     = 40;
  localparam int unsigned NumRows        = 32;

  localparam logic [CfgIdxW-1:0]  CfgSpareFirst = 3'd4;
  localparam logic [CfgIdxW-1:0]  CfgSpareLast  = 3'd7;
  localparam logic [CfgDataW-1:0] Word3Mask     = {{(CfgDataW-Word3W){1'b0}}, {Word3W{1'b1}}};
  localparam logic [CfgDataW-1:0] AllMaxWeights = {4{16'h7fff}};
  localparam logic [CfgDataW-1:0] AllMinWeights = {4{16'h8000}};
  localparam logic [WeightW-1:0]  WeightMax     = 16'h7fff;
  localparam logic [WeightW-1:0]  WeightMin     = 16'h8000;

  typedef enum logic [1:0] {
    RowWrite,
    RowPoint,
    RowPointKnown
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CfgIdxW-1:0]    index;
    logic [CfgDataW-1:0]   data;
    coord_t                x;
    coord_t                y;
    res_t                  aberration;
    logic                  saturated;
  } stim_row_t;

  typedef struct packed {
    res_t aberration;
    logic saturated;
  } wavefront_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  coord_t              pupil_x;
  coord_t              pupil_y;
  logic                result_valid;
  res_t                aberration;
  logic                saturated;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // weights as the block should hold them
  logic [CfgDataW-1:0] coeff_words [NumWords];
  wavefront_t          wavefront_q [$];
  // a directed row may carry its result typed in
  logic                known_valid;
  wavefront_t          known_result;
  int unsigned         mismatch_count;
  int unsigned         stall_cycles;
  stim_row_t           directed_rows [NumRows];

  zernike_aberration_eval i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pupil_x_i      (pupil_x),
    .pupil_y_i      (pupil_y),
    .result_valid_o (result_valid),
    .aberration_o   (aberration),
    .saturated_o    (saturated),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic wavefront_t predict_wavefront(coord_t px, coord_t py);
    longint     x, y, x1, y1, x2, y2, xy;
    longint     x3, y3, x2y, xy2, x4, y4, x2y2, x3y, xy3;
    longint     one, sum, rounded;
    longint     term [NumTerms];
    weight_t    w;
    wavefront_t r;
    x   = longint'(px);
    y   = longint'(py);
    one = longint'(OneQ30);
    x1  = x * 32768;
    y1  = y * 32768;
    x2  = x * x;
    y2  = y * y;
    xy  = x * y;
    // degree 3 and 4 monomials are floored back to q30
    x3   = (x2 * x) >>> Deg3Shift;
    y3   = (y2 * y) >>> Deg3Shift;
    x2y  = (x2 * y) >>> Deg3Shift;
    xy2  = (y2 * x) >>> Deg3Shift;
    x4   = (x2 * x2) >>> Deg4Shift;
    y4   = (y2 * y2) >>> Deg4Shift;
    x2y2 = (x2 * y2) >>> Deg4Shift;
    x3y  = (x2 * xy) >>> Deg4Shift;
    xy3  = (xy * y2) >>> Deg4Shift;
    term[0]  = one;
    term[1]  = y1;
    term[2]  = x1;
    term[3]  = 2 * (x2 + y2) - one;
    term[4]  = y2 - x2;
    term[5]  = 2 * xy;
    term[6]  = -2 * y1 + 3 * y3 + 3 * x2y;
    term[7]  = -2 * x1 + 3 * x3 + 3 * xy2;
    term[8]  = y3 - 3 * x2y;
    term[9]  = -x3 + 3 * xy2;
    term[10] = one - 6 * x2 - 6 * y2 + 6 * x4 + 12 * x2y2 + 6 * y4;
    term[11] = 3 * x2 - 3 * y2 - 4 * x4 + 4 * y4;
    term[12] = -6 * xy + 8 * x3y + 8 * xy3;
    term[13] = x4 - 6 * x2y2 + y4;
    term[14] = -4 * x3y + 4 * xy3;
    sum = 0;
    for (int i = 0; i < NumTerms; i++) begin
      w   = coeff_words[i / GroupSize][(i % GroupSize) * WeightW +: WeightW];
      sum = sum + term[i] * longint'(w);
    end
    rounded = (sum + longint'(RoundHalf)) >>> OutShift;
    r.saturated = 1'b1;
    if (rounded > longint'(ResMax)) begin
      r.aberration = res_t'(ResMax);
    end else if (rounded < longint'(ResMin)) begin
      r.aberration = res_t'(ResMin);
    end else begin
      r.aberration = res_t'(rounded);
      r.saturated  = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxPrinted) begin
      $display("tb: mismatch at %0t ns: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // results are checked before new requests are queued
  always @(posedge clk_i) begin : check_results
    wavefront_t want;
    if (rst_ni) begin
      if (result_valid) begin
        if (wavefront_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = wavefront_q.pop_front();
          if (aberration !== want.aberration) begin
            report_mismatch($sformatf("aberration %0d, expected %0d",
                                      aberration, want.aberration));
          end
          if (saturated !== want.saturated) begin
            report_mismatch($sformatf("saturated %b, expected %b",
                                      saturated, want.saturated));
          end
        end
      end
      if (start && !busy) begin
        if (known_valid) begin
          wavefront_q.push_back(known_result);
        end else begin
          wavefront_q.push_back(predict_wavefront(pupil_x, pupil_y));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  function automatic coord_t pick_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (r)
      0, 1, 2:  return coord_t'(-32768);
      3, 4:     return coord_t'(32767);
      5:        return coord_t'(-32767);
      6:        return coord_t'(-1);
      7:        return coord_t'(0);
      8:        return coord_t'(1);
      default:  return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_weight_word();
    logic [CfgDataW-1:0] word;
    word = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      for (int f = 0; f < GroupSize; f++) begin
        case ($urandom_range(0, 4))
          0: word[f * WeightW +: WeightW] = WeightMax;
          1: word[f * WeightW +: WeightW] = WeightMin;
          2: word[f * WeightW +: WeightW] = '0;
          default: ;
        endcase
      end
    end
    return word;
  endfunction

  // lowers start and waits for every outstanding result
  task automatic wait_for_drain();
    start = 1'b0;
    while (wavefront_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_coeff_word(input logic [CfgIdxW-1:0] index,
                                  input logic [CfgDataW-1:0] data);
    wait_for_drain();
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk_i); while (!cfg_ready);
    case (index)
      CfgWord0, CfgWord1, CfgWord2: coeff_words[index] = data;
      CfgWord3: coeff_words[CfgWord3] = data & Word3Mask;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // called at a falling edge; returns at a falling edge with start still
  // high when there is no gap
  task automatic drive_point(input coord_t x, input coord_t y, input logic known,
                             input wavefront_t result, input int unsigned gap);
    start        = 1'b1;
    pupil_x      = x;
    pupil_y      = y;
    known_valid  = known;
    known_result = result;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin : stimulus
    stim_row_t   row;
    logic        steady;
    int unsigned n_row;
    rst_ni         = 1'b0;
    start          = 1'b0;
    pupil_x        = '0;
    pupil_y        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CfgWord0;
    cfg_data       = '0;
    known_valid    = 1'b0;
    known_result   = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    for (int k = 0; k < NumWords; k++) coeff_words[k] = '0;

    directed_rows = '{
      // weights are all zero out of reset
      '{RowPointKnown, CfgWord0, 64'h0, 16'sd32767, -16'sd32768, 32'sd0, 1'b0},
      '{RowPointKnown, CfgWord0, 64'h0, -16'sd32768, -16'sd32768, 32'sd0, 1'b0},
      // piston alone gives the weight whatever the point
      '{RowWrite, CfgWord0, 64'h0000_0000_0000_7fff, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowPointKnown, CfgWord0, 64'h0, 16'sd0, 16'sd0, 32'sd524272, 1'b0},
      '{RowPointKnown, CfgWord0, 64'h0, -16'sd32768, 16'sd32767, 32'sd524272, 1'b0},
      '{RowWrite, CfgWord0, 64'h0000_0000_0000_8000, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowPointKnown, CfgWord0, 64'h0, 16'sd12345, -16'sd222, -32'sd524288, 1'b0},
      // tilt x of 4.0 at the left edge of the pupil
      '{RowWrite, CfgWord0, 64'h0000_4000_0000_0000, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowPointKnown, CfgWord0, 64'h0, -16'sd32768, 16'sd0, -32'sd262144, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, 16'sd32767, 16'sd0, 32'sd0, 1'b0},
      // every weight at its top, word 3 with junk above its width
      '{RowWrite, CfgWord0, AllMaxWeights, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowWrite, CfgWord1, AllMaxWeights, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowWrite, CfgWord2, AllMaxWeights, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowWrite, CfgWord3, 64'hffff_7fff_7fff_7fff, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      // unused index must not alias onto word 0
      '{RowWrite, CfgSpareFirst, 64'h0, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, -16'sd32768, -16'sd32768, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, 16'sd32767, 16'sd32767, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, -16'sd32768, 16'sd32767, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, 16'sd32767, -16'sd32768, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, 16'sd1, -16'sd1, 32'sd0, 1'b0},
      // every weight at its bottom
      '{RowWrite, CfgWord0, AllMinWeights, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowWrite, CfgWord1, AllMinWeights, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowWrite, CfgWord2, AllMinWeights, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowWrite, CfgWord3, 64'h0000_8000_8000_8000, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowWrite, CfgSpareLast, AllMaxWeights, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, -16'sd32768, -16'sd32768, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, 16'sd32767, 16'sd32767, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, -16'sd32768, 16'sd32767, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, 16'sd23170, -16'sd23170, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, -16'sd1, 16'sd0, 32'sd0, 1'b0},
      '{RowPoint, CfgWord0, 64'h0, 16'sd0, -16'sd32768, 32'sd0, 1'b0}
    };

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (n_row = 0; n_row < NumRows; n_row++) begin
      row = directed_rows[n_row];
      if (row.kind == RowWrite) begin
        write_coeff_word(row.index, row.data);
      end else begin
        drive_point(row.x, row.y, row.kind == RowPointKnown,
                    '{aberration: row.aberration, saturated: row.saturated},
                    pick_gap());
      end
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      for (int k = 0; k < NumWords; k++) begin
        write_coeff_word(cfg_idx_e'(k), pick_weight_word());
      end
      if ($urandom_range(0, 1) != 0) begin
        write_coeff_word(CfgIdxW'($urandom_range(CfgSpareFirst, CfgSpareLast)),
                         {$urandom, $urandom});
      end
      // one phase streams back to back with no gaps, apart from the rare random drain
      steady = (phase == 1);
      for (int n = 0; n < PointsPerPhase; n++) begin
        if ((phase == 2 && n == PointsPerPhase / 2) || $urandom_range(0, 99) == 0) begin
          wait_for_drain();
        end
        drive_point(pick_coord(), pick_coord(), 1'b0, '0, steady ? 0 : pick_gap());
      end
    end

    wait_for_drain();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
sv/zae_pkg.sv
sv/zernike_aberration_eval.sv
tb/zernike_aberration_eval_test.sv
